// ----- rtl/pxd_pkg.sv -----
// ============================================================================
// pxd_pkg - shared types and constants for the pooled xorshift draw core
// Defaults, pool reset words, reciprocal constants and the sequencer states.
// ============================================================================
package pxd_pkg;

    localparam int POOL_SIZE_DEF = 7;
    localparam int ROUNDS_DEF    = 50;

    // request kinds carried on s_tuser
    localparam logic OP_DRAW  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [31:0] MULT_KEY = 32'd672657529;

    // counter lanes and the divisor that picks the bit of w
    localparam int LANE_DIV = 3;
    localparam int BIT_DIV  = 10;

    // floor(2^32 / d): quotient estimate is at most one low
    localparam logic [31:0] RECIP_LANE = 32'((64'd1 << 32) / LANE_DIV);
    localparam logic [31:0] RECIP_BIT  = 32'((64'd1 << 32) / BIT_DIV);

    localparam int SEED_DEPTH = 16;
    localparam logic [31:0] SEED_WORDS [SEED_DEPTH] = '{
        32'h7498_4356, 32'h1541_8613, 32'h5468_7486, 32'h1531_3468,
        32'h7443_5138, 32'h4684_1653, 32'h1458_6468, 32'h0000_0000,
        32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
        32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FOLD,
        ST_P0,
        ST_P1,
        ST_P2,
        ST_P3,
        ST_P4,
        ST_P5,
        ST_FIN,
        ST_OUT
    } state_t;

    function automatic logic [31:0] seed_word(input logic [3:0] idx);
        return SEED_WORDS[idx];
    endfunction

endpackage

// ----- rtl/pxd_pool_mem.sv -----
// ============================================================================
// pxd_pool_mem - pool word memory
// One write port, two registered read ports; unwritten words read as seeds.
// ============================================================================
module pxd_pool_mem #(
    parameter int POOL_SIZE = pxd_pkg::POOL_SIZE_DEF,
    parameter int IDX_W     = $clog2(POOL_SIZE)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [31:0]      wr_data,
    input  logic [IDX_W-1:0] rd_a_addr,
    input  logic [IDX_W-1:0] rd_b_addr,
    output logic [31:0]      rd_a_data,
    output logic [31:0]      rd_b_data
);

    logic [31:0]          mem [POOL_SIZE];
    logic [POOL_SIZE-1:0] valid_reg;
    logic [31:0]          rd_a_reg;
    logic [31:0]          rd_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= valid_reg[rd_a_addr] ? mem[rd_a_addr] : pxd_pkg::seed_word(4'(rd_a_addr));
        rd_b_reg <= valid_reg[rd_b_addr] ? mem[rd_b_addr] : pxd_pkg::seed_word(4'(rd_b_addr));
    end

    assign rd_a_data = rd_a_reg;
    assign rd_b_data = rd_b_reg;

endmodule

// ----- rtl/pxd_mul_unit.sv -----
// ============================================================================
// pxd_mul_unit - shared 32x32 multiplier
// Full 64-bit product, registered; one new operand pair each cycle.
// ============================================================================
module pxd_mul_unit (
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(a) * 64'(b);
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/pooled_xorshift_three_number_draw_core.sv -----
// ============================================================================
// pooled_xorshift_three_number_draw_core - pooled xorshift three-number draw
// Pool of 32-bit words, XOR-folded into a xorshift32 seed, mixed over rounds.
// ============================================================================
// Result: a draw shows its result after the fold, the rounds, FIN and OUT, if
//   m_tdata is free; s_tready rises with it.
// Occupancy: s_tready stays low until the result is out, so a new request waits
//   for the last draw; the shared multiplier does six products per round.
// Reset: rst_n (async, active low) idles the sequencer, drops m_tvalid and
//   returns every pool word to its seed value at once.
//
// Per round the sequencer walks six phases around one registered multiplier:
//   P0  x = xs(seed), x * recip(P)      ; retire previous round (RMW + count)
//   P1  x * recip(3)                    ; reduce x mod P
//   P2  y = xs(seed), y * recip(P)      ; reduce x mod 3 (counter lane)
//   P3  z = xs(seed), z * recip(P)      ; reduce y mod P
//   P4  r = xs(seed), r * recip(10)     ; reduce z mod P, read pool[y]
//   P5  pool[y] * MULT_KEY              ; reduce r mod 10, read pool[x], pool[z]
// A reduction takes the high word of the product as quotient estimate (never
// more than one low), so the remainder needs one compare and subtract. The
// last round retires in FIN; OUT then waits for a free output register.
module pooled_xorshift_three_number_draw_core #(
    parameter int POOL_SIZE = pxd_pkg::POOL_SIZE_DEF,
    parameter int ROUNDS    = pxd_pkg::ROUNDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [2:0] word_index, [34:3] word_value, [39:35] zero
    input  logic        s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [5:0] number_a, [11:6] number_b,
                                   // [17:12] number_c, [18] all_equal, [23:19] zero
);

    localparam int IDX_W   = $clog2(POOL_SIZE);
    localparam int PTR_W   = $clog2(POOL_SIZE + 1);
    localparam int RND_W   = $clog2(ROUNDS + 1);
    localparam int CNT_W   = $clog2(ROUNDS + 2);
    localparam int LANES   = 3;
    localparam logic [31:0] RECIP_POOL = 32'((64'd1 << 32) / POOL_SIZE);

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    function automatic logic [31:0] xs_step(input logic [31:0] s);
        logic [31:0] v;
        v = s ^ (s << 13);
        v = v ^ (v >> 17);
        v = v ^ (v << 5);
        return v;
    endfunction

    // remainder from low bits: true value - q_est*d lies in [0, 2d), d <= 16
    function automatic logic [3:0] mod_fix(input logic [5:0] v6, input logic [5:0] q6,
                                           input logic [4:0] d);
        logic [10:0] qd;
        logic [5:0]  r;
        qd = 11'(q6) * 11'(d);
        r  = v6 - qd[5:0];
        if (r >= 6'(d))
        begin
            r = r - 6'(d);
        end
        return r[3:0];
    endfunction

    function automatic logic [5:0] sat6(input logic [CNT_W-1:0] c);
        logic [CNT_W+5:0] e;
        e = (CNT_W + 6)'(c);
        return (e > (CNT_W + 6)'(63)) ? 6'd63 : e[5:0];
    endfunction

    // ------------------------------------------------------------------
    // request fields
    // ------------------------------------------------------------------
    logic        op;
    logic [2:0]  word_index;
    logic [31:0] word_value;
    logic        in_acc;

    assign op         = s_tuser;
    assign word_index = s_tdata[2:0];
    assign word_value = s_tdata[34:3];
    assign in_acc     = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    pxd_pkg::state_t  state_reg, state_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [RND_W-1:0] rnd_reg, rnd_next;
    logic             first_reg, first_next;
    logic             out_valid_reg, out_valid_next;

    logic [31:0]      seed_reg, seed_next;
    logic [31:0]      x_reg, x_next;
    logic [5:0]       op_lo_reg, op_lo_next;
    logic [IDX_W-1:0] xi_reg, xi_next;
    logic [IDX_W-1:0] yi_reg, yi_next;
    logic [IDX_W-1:0] zi_reg, zi_next;
    logic [1:0]       ci_reg, ci_next;
    logic [3:0]       ri_reg, ri_next;
    logic [CNT_W-1:0] cnt_reg [LANES];
    logic [CNT_W-1:0] cnt_next [LANES];
    logic [23:0]      out_reg, out_next;

    // shared unit and memory hookup
    logic [31:0]      mul_a, mul_b;
    logic [63:0]      prod;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr, rd_a_addr, rd_b_addr;
    logic [31:0]      wr_data, pool_a, pool_b;

    logic [31:0]      xs_val;
    logic [4:0]       div_cur;
    logic [3:0]       rem;
    logic [31:0]      w;
    logic             retire;
    logic             all_eq;

    pxd_mul_unit u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    pxd_pool_mem #(
        .POOL_SIZE (POOL_SIZE),
        .IDX_W     (IDX_W)
    ) u_pool (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a_data (pool_a),
        .rd_b_data (pool_b)
    );

    assign s_tready = (state_reg == pxd_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    assign xs_val  = xs_step(seed_reg);
    assign div_cur = (state_reg == pxd_pkg::ST_P2) ? 5'(pxd_pkg::LANE_DIV) :
                     (state_reg == pxd_pkg::ST_P5) ? 5'(pxd_pkg::BIT_DIV) :
                                                     5'(POOL_SIZE);
    assign rem     = mod_fix(op_lo_reg, prod[37:32], div_cur);

    // w of the round being retired: pool[y]*key from the multiplier, pool[z] on port B
    assign w      = prod[31:0] + pool_b;
    assign retire = ((state_reg == pxd_pkg::ST_P0) && !first_reg)
                 || (state_reg == pxd_pkg::ST_FIN);

    // pool write: retire RMW has port A holding old pool[x]
    assign wr_en   = retire
                  || (in_acc && (op == pxd_pkg::OP_WRITE) && (32'(word_index) < POOL_SIZE));
    assign wr_addr = retire ? xi_reg : IDX_W'(word_index);
    assign wr_data = retire ? (pool_a ^ w) : word_value;

    assign rd_a_addr = ((state_reg == pxd_pkg::ST_FOLD) && (32'(ptr_reg) < POOL_SIZE))
                           ? ptr_reg[IDX_W-1:0] :
                       (state_reg == pxd_pkg::ST_P4) ? yi_reg : xi_reg;
    assign rd_b_addr = zi_reg;

    assign all_eq = (cnt_reg[0] == cnt_reg[1]) && (cnt_reg[1] == cnt_reg[2]);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        rnd_next       = rnd_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg;
        seed_next      = seed_reg;
        x_next         = x_reg;
        op_lo_next     = op_lo_reg;
        xi_next        = xi_reg;
        yi_next        = yi_reg;
        zi_next        = zi_reg;
        ci_next        = ci_reg;
        ri_next        = ri_reg;
        out_next       = out_reg;
        mul_a          = xs_val;
        mul_b          = RECIP_POOL;
        for (int i = 0; i < LANES; i++)
        begin
            cnt_next[i] = cnt_reg[i];
        end

        if (m_tvalid && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (retire)
        begin
            cnt_next[ci_reg] = cnt_reg[ci_reg] + CNT_W'(w[{1'b0, ri_reg}]);
        end

        unique case (state_reg)
            pxd_pkg::ST_IDLE:
            begin
                if (in_acc && (op == pxd_pkg::OP_DRAW))
                begin
                    state_next = pxd_pkg::ST_FOLD;
                    ptr_next   = '0;
                    rnd_next   = '0;
                    seed_next  = '0;
                    for (int i = 0; i < LANES; i++)
                    begin
                        cnt_next[i] = CNT_W'(1);
                    end
                end
            end
            pxd_pkg::ST_FOLD:
            begin
                // read issued at ptr lands in the next FOLD step
                if (ptr_reg != '0)
                begin
                    seed_next = seed_reg ^ pool_a;
                end
                ptr_next = ptr_reg + PTR_W'(1);
                if (ptr_reg == PTR_W'(POOL_SIZE))
                begin
                    state_next = pxd_pkg::ST_P0;
                    first_next = 1'b1;
                end
            end
            pxd_pkg::ST_P0:
            begin
                seed_next  = xs_val;
                x_next     = xs_val;
                op_lo_next = xs_val[5:0];
                state_next = pxd_pkg::ST_P1;
            end
            pxd_pkg::ST_P1:
            begin
                mul_a      = x_reg;
                mul_b      = pxd_pkg::RECIP_LANE;
                op_lo_next = x_reg[5:0];
                xi_next    = rem[IDX_W-1:0];
                state_next = pxd_pkg::ST_P2;
            end
            pxd_pkg::ST_P2:
            begin
                seed_next  = xs_val;
                op_lo_next = xs_val[5:0];
                ci_next    = rem[1:0];
                state_next = pxd_pkg::ST_P3;
            end
            pxd_pkg::ST_P3:
            begin
                seed_next  = xs_val;
                op_lo_next = xs_val[5:0];
                yi_next    = rem[IDX_W-1:0];
                state_next = pxd_pkg::ST_P4;
            end
            pxd_pkg::ST_P4:
            begin
                seed_next  = xs_val;
                mul_b      = pxd_pkg::RECIP_BIT;
                op_lo_next = xs_val[5:0];
                zi_next    = rem[IDX_W-1:0];
                state_next = pxd_pkg::ST_P5;
            end
            pxd_pkg::ST_P5:
            begin
                mul_a      = pool_a;
                mul_b      = pxd_pkg::MULT_KEY;
                ri_next    = rem;
                first_next = 1'b0;
                rnd_next   = rnd_reg + RND_W'(1);
                if (rnd_reg == RND_W'(ROUNDS - 1))
                begin
                    state_next = pxd_pkg::ST_FIN;
                end
                else
                begin
                    state_next = pxd_pkg::ST_P0;
                end
            end
            pxd_pkg::ST_FIN:
            begin
                state_next = pxd_pkg::ST_OUT;
            end
            pxd_pkg::ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_next       = {5'b0, all_eq, sat6(cnt_reg[2]), sat6(cnt_reg[1]),
                                      sat6(cnt_reg[0])};
                    out_valid_next = 1'b1;
                    state_next     = pxd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pxd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pxd_pkg::ST_IDLE;
            ptr_reg       <= '0;
            rnd_reg       <= '0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            rnd_reg       <= rnd_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seed_reg  <= seed_next;
        x_reg     <= x_next;
        op_lo_reg <= op_lo_next;
        xi_reg    <= xi_next;
        yi_reg    <= yi_next;
        zi_reg    <= zi_next;
        ci_reg    <= ci_next;
        ri_reg    <= ri_next;
        out_reg   <= out_next;
        for (int i = 0; i < LANES; i++)
        begin
            cnt_reg[i] <= cnt_next[i];
        end
    end

endmodule

// ----- rtl/pxd_checker.sv -----
// ============================================================================
// pxd_checker - port-level checks for the pooled xorshift draw core
// Watches the request and result streams; bound to the top level.
// ============================================================================
module pxd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // a draw occupies the block
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == pxd_pkg::OP_DRAW)) |=> !s_tready)
        else $error("s_tready high right after a draw request");

    // a pool write finishes in its own cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == pxd_pkg::OP_WRITE)) |=> s_tready)
        else $error("block busy after a write request");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // counters start at one
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[5:0] != 6'd0) && (m_tdata[11:6] != 6'd0)
                      && (m_tdata[17:12] != 6'd0)))
        else $error("drawn number is zero");

    // equal flag agrees with the numbers
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[18]) |-> ((m_tdata[5:0] == m_tdata[11:6])
                                       && (m_tdata[11:6] == m_tdata[17:12])))
        else $error("all_equal set on differing numbers");

endmodule

bind pooled_xorshift_three_number_draw_core pxd_checker u_pxd_checker (.*);
